### hdl/wmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

    // row length limit default
    localparam int ROW_LEN_MAX_DEF = 4096;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMOD_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 1'd1;

    // datapath widths
    localparam int W_W    = 16;
    localparam int MUL_BW = 25;
    localparam int PROD_W = W_W + MUL_BW;
    localparam int SUM_W  = 48;
    localparam int EPS_W  = 24;
    localparam int COEF_W = 24;
    localparam int RAD_W  = SUM_W + 1;

    // square root and divide unit
    localparam int ROOT_W     = 25;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SUB_W      = REM_W + 2;
    localparam int QUO_W      = 29;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_W     = 5;

    localparam logic [COEF_W-1:0] COEF_ONE = 24'd65536;
    localparam logic [COEF_W-1:0] COEF_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic                  opcode;
        logic signed [W_W-1:0] weight;
        logic signed [W_W-1:0] style;
        logic                  last_in_row;
    } item_t;

    typedef struct packed {
        logic signed [W_W-1:0] out_weight;
        logic [COEF_W-1:0]     coefficient;
        logic                  coef_valid;
        logic                  saturated;
    } result_t;

    // status from the root and divide unit
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [COEF_W-1:0] coef;
    } root_res_t;

endpackage

`default_nettype wire

### hdl/wmd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wmd_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/wmd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module wmd_mul
    import wmd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic signed [W_W-1:0]    op_a,
    input  wire logic signed [MUL_BW-1:0] op_b,
    output logic signed [PROD_W-1:0]      prod
);

    // shared signed multiplier with registered product
    always_ff @(posedge clk)
    begin
        prod <= op_a * op_b;
    end

endmodule

`default_nettype wire

### hdl/wmd_root_div.sv
`timescale 1ns / 1ps
`default_nettype none

module wmd_root_div
    import wmd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RAD_W-1:0] radicand,
    output root_res_t             res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SQRT = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]        ph_reg, ph_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAD_W:0]    rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              done_reg, done_next;
    logic              sat_reg, sat_next;
    logic [COEF_W-1:0] coef_reg, coef_next;

    logic [SUB_W-1:0]  sub_a, sub_b;
    logic [SUB_W:0]    sub_diff;
    logic              sub_ge;
    logic              num_bit;

    // single subtractor shared by root and divide steps
    assign num_bit = (step_reg == STEP_W'(DIV_STEPS - 1));

    always_comb
    begin
        case (ph_reg)
            PH_SQRT:
            begin
                sub_a = {rem_reg, rad_reg[RAD_W:RAD_W-1]};
                sub_b = {1'b0, root_reg, 2'b01};
            end
            PH_DIV:
            begin
                sub_a = {1'b0, rem_reg, num_bit};
                sub_b = {3'b000, root_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[SUB_W];
    end

    // sequencer: one root digit, then one quotient bit, per cycle
    always_comb
    begin
        ph_next   = ph_reg;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        coef_next = coef_reg;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    ph_next   = PH_SQRT;
                    step_next = STEP_W'(SQRT_STEPS - 1);
                    rad_next  = {1'b0, radicand};
                    rem_next  = '0;
                    root_next = '0;
                end
            end
            PH_SQRT:
            begin
                rad_next = {rad_reg[RAD_W-2:0], 2'b00};
                if (sub_ge)
                begin
                    rem_next  = sub_diff[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sub_a[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (root_next == '0)
                    begin
                        // zero radicand saturates the coefficient
                        ph_next   = PH_IDLE;
                        done_next = 1'b1;
                        sat_next  = 1'b1;
                        coef_next = COEF_MAX;
                    end
                    else
                    begin
                        ph_next   = PH_DIV;
                        step_next = STEP_W'(DIV_STEPS - 1);
                        rem_next  = '0;
                        quo_next  = '0;
                    end
                end
            end
            PH_DIV:
            begin
                if (sub_ge)
                begin
                    rem_next = sub_diff[REM_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sub_a[REM_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    ph_next   = PH_IDLE;
                    done_next = 1'b1;
                    if (quo_next[QUO_W-1:COEF_W] != '0)
                    begin
                        sat_next  = 1'b1;
                        coef_next = COEF_MAX;
                    end
                    else
                    begin
                        sat_next  = 1'b0;
                        coef_next = quo_next[COEF_W-1:0];
                    end
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        coef_reg <= coef_next;
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.coef = coef_reg;

endmodule

`default_nettype wire

### hdl/weight_modulate_demodulate_core.sv
// Sequence: an item is taken in S_IDLE and passes S_MOD, S_MUL2, S_POST and S_OUT;
// a row end with demodulation on also waits in S_ROOT for the bit-serial square root
// and divide. Throughput: one item in flight at a time, and S_OUT waits while a result
// is pending and not taken; a demodulated row end holds the input for the root and divide.
// Reset: asynchronous active low; sum and row count cleared, coefficient 1.0,
// demod_enable 1, epsilon 1, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module weight_modulate_demodulate_core
    import wmd_pkg::*;
#(
    parameter int ROW_LEN_MAX = ROW_LEN_MAX_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wmd_stream_if.sink                 item,
    wmd_stream_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(ROW_LEN_MAX + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic                  op_reg, op_next;
    logic                  last_reg, last_next;
    logic signed [W_W-1:0] wp_reg, wp_next;
    logic                  sat_reg, sat_next;
    logic [W_W-1:0]        ow_reg, ow_next;
    logic [COEF_W-1:0]     coef_reg, coef_next;
    logic                  cv_reg, cv_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COEF_W-1:0]     held_reg, held_next;
    logic                  demod_reg;
    logic [EPS_W-1:0]      eps_reg;
    logic                  rvalid_reg, rvalid_next;
    result_t               res_reg, res_next;

    logic signed [W_W-1:0]    mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W:0]   prod_ext;
    logic signed [PROD_W:0]   rnd_mod, rnd_scl;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_sat;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     row_end;
    logic                     root_start;
    logic [RAD_W-1:0]         radicand;
    root_res_t                root_res;
    logic                     slot_free;

    // multiplier operand selection
    always_comb
    begin
        case (state_reg)
            S_MUL2:
            begin
                mul_a = wp_reg;
                if (op_reg)
                    mul_b = {1'b0, held_reg};
                else
                    mul_b = {{(MUL_BW-W_W){wp_reg[W_W-1]}}, wp_reg};
            end
            default:
            begin
                mul_a = item.payload.weight;
                mul_b = {{(MUL_BW-W_W){item.payload.style[W_W-1]}}, item.payload.style};
            end
        endcase
    end

    wmd_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // rounding of the product for both Q4.12 results
    assign prod_ext = {prod[PROD_W-1], prod};
    assign rnd_mod  = (prod_ext + (PROD_W+1)'(2048)) >>> 12;
    assign rnd_scl  = (prod_ext + (PROD_W+1)'(32768)) >>> 16;

    // square accumulation with saturation
    assign sum_add = {1'b0, sum_reg} + {{(SUM_W+1-32){1'b0}}, prod[31:0]};
    assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign radicand = {1'b0, sum_sat} + {{(RAD_W-EPS_W){1'b0}}, eps_reg};

    // row end on the marker or at the length limit
    assign cnt_inc = cnt_reg + 1'b1;
    assign row_end = last_reg || (cnt_inc >= CNT_W'(ROW_LEN_MAX));

    assign slot_free = !rvalid_reg || result.ready;

    // item sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        last_next   = last_reg;
        wp_next     = wp_reg;
        sat_next    = sat_reg;
        ow_next     = ow_reg;
        coef_next   = coef_reg;
        cv_next     = cv_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        held_next   = held_reg;
        res_next    = res_reg;
        rvalid_next = rvalid_reg && !result.ready;
        root_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next    = item.payload.opcode;
                    last_next  = item.payload.last_in_row;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                // modulated weight, round half up and clamp
                if (rnd_mod > (PROD_W+1)'(32767))
                begin
                    wp_next  = 16'sh7FFF;
                    sat_next = 1'b1;
                end
                else if (rnd_mod < -(PROD_W+1)'(32768))
                begin
                    wp_next  = -16'sh8000;
                    sat_next = 1'b1;
                end
                else
                begin
                    wp_next  = rnd_mod[W_W-1:0];
                    sat_next = 1'b0;
                end
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                coef_next  = '0;
                cv_next    = 1'b0;
                state_next = S_OUT;
                if (!op_reg)
                begin
                    ow_next  = wp_reg;
                    sat_next = sat_reg || sum_add[SUM_W];
                    if (row_end)
                    begin
                        sum_next = '0;
                        cnt_next = '0;
                        cv_next  = 1'b1;
                        if (demod_reg)
                        begin
                            root_start = 1'b1;
                            state_next = S_ROOT;
                        end
                        else
                        begin
                            coef_next = COEF_ONE;
                            held_next = COEF_ONE;
                        end
                    end
                    else
                    begin
                        sum_next = sum_sat;
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    // scale pass, round half up and clamp
                    if (rnd_scl > (PROD_W+1)'(32767))
                    begin
                        ow_next  = 16'h7FFF;
                        sat_next = 1'b1;
                    end
                    else if (rnd_scl < -(PROD_W+1)'(32768))
                    begin
                        ow_next  = 16'h8000;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        ow_next = rnd_scl[W_W-1:0];
                    end
                end
            end
            S_ROOT:
            begin
                if (root_res.done)
                begin
                    coef_next  = root_res.coef;
                    held_next  = root_res.coef;
                    sat_next   = sat_reg || root_res.sat;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    res_next.out_weight  = ow_reg;
                    res_next.coefficient = coef_reg;
                    res_next.coef_valid  = cv_reg;
                    res_next.saturated   = sat_reg;
                    rvalid_next          = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    wmd_root_div u_root_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .res      (root_res)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rvalid_reg <= 1'b0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            held_reg   <= COEF_ONE;
            demod_reg  <= 1'b1;
            eps_reg    <= EPS_W'(1);
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            held_reg   <= held_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEMOD_ENABLE: demod_reg <= cfg_data[0];
                    CFG_EPSILON:      eps_reg   <= cfg_data[EPS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // item payload and result registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        last_reg <= last_next;
        wp_reg   <= wp_next;
        sat_reg  <= sat_next;
        ow_reg   <= ow_next;
        coef_reg <= coef_next;
        cv_reg   <= cv_next;
        res_reg  <= res_next;
    end

    assign item.ready     = (state_reg == S_IDLE);
    assign result.valid   = rvalid_reg;
    assign result.payload = res_reg;

    // one item in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input taken while an item is in flight");

    // root unit only reports while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        root_res.done |-> (state_reg == S_ROOT))
        else $error("root unit done outside the root wait");

    // row count always below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(ROW_LEN_MAX))
        else $error("row count reached the limit");

    // coefficient field is zero unless it carries a new coefficient
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.payload.coef_valid) |-> (result.payload.coefficient == '0))
        else $error("coefficient set without coef_valid");

endmodule

`default_nettype wire
